// ----- sv/prwh_pkg.sv -----
package prwh_pkg;

  localparam int SUM_WIDTH = 32;
  localparam int NUM_BINS  = 18;
  localparam int BIN_W     = 5;
  localparam int COORD_W   = 20;
  localparam int BOX_W     = 25;
  localparam logic [BIN_W-1:0] LAST_BIN_IDX = BIN_W'(NUM_BINS - 1);
  localparam logic [BIN_W-1:0] CATCH_BIN    = BIN_W'(NUM_BINS - 1);

  // classified word handed from front to back
  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic [15:0]      weight;
    logic             last;
  } job_t;

  // quarter-wave sine, Q1.14
  function automatic logic [14:0] quarter_sine(input logic [6:0] i);
    logic [14:0] v;
    case (i)
      7'd0: v = 15'd0;      7'd1: v = 15'd402;    7'd2: v = 15'd804;
      7'd3: v = 15'd1205;   7'd4: v = 15'd1606;   7'd5: v = 15'd2006;
      7'd6: v = 15'd2404;   7'd7: v = 15'd2801;   7'd8: v = 15'd3196;
      7'd9: v = 15'd3590;   7'd10: v = 15'd3981;  7'd11: v = 15'd4370;
      7'd12: v = 15'd4756;  7'd13: v = 15'd5139;  7'd14: v = 15'd5520;
      7'd15: v = 15'd5897;  7'd16: v = 15'd6270;  7'd17: v = 15'd6639;
      7'd18: v = 15'd7005;  7'd19: v = 15'd7366;  7'd20: v = 15'd7723;
      7'd21: v = 15'd8076;  7'd22: v = 15'd8423;  7'd23: v = 15'd8765;
      7'd24: v = 15'd9102;  7'd25: v = 15'd9434;  7'd26: v = 15'd9760;
      7'd27: v = 15'd10080; 7'd28: v = 15'd10394; 7'd29: v = 15'd10702;
      7'd30: v = 15'd11003; 7'd31: v = 15'd11297; 7'd32: v = 15'd11585;
      7'd33: v = 15'd11866; 7'd34: v = 15'd12140; 7'd35: v = 15'd12406;
      7'd36: v = 15'd12665; 7'd37: v = 15'd12916; 7'd38: v = 15'd13160;
      7'd39: v = 15'd13395; 7'd40: v = 15'd13623; 7'd41: v = 15'd13842;
      7'd42: v = 15'd14053; 7'd43: v = 15'd14256; 7'd44: v = 15'd14449;
      7'd45: v = 15'd14635; 7'd46: v = 15'd14811; 7'd47: v = 15'd14978;
      7'd48: v = 15'd15137; 7'd49: v = 15'd15286; 7'd50: v = 15'd15426;
      7'd51: v = 15'd15557; 7'd52: v = 15'd15679; 7'd53: v = 15'd15791;
      7'd54: v = 15'd15893; 7'd55: v = 15'd15986; 7'd56: v = 15'd16069;
      7'd57: v = 15'd16143; 7'd58: v = 15'd16207; 7'd59: v = 15'd16261;
      7'd60: v = 15'd16305; 7'd61: v = 15'd16340; 7'd62: v = 15'd16364;
      7'd63: v = 15'd16379; 7'd64: v = 15'd16384;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

  // region bounds in hundredths: x lo, x hi, y lo, y hi
  function automatic logic signed [7:0] box(input logic [4:0] k, input logic [1:0] c);
    logic signed [7:0] b [0:3];
    case (k)
      5'd0:  b = '{-8'sd50, -8'sd16, -8'sd1,  8'sd50};
      5'd1:  b = '{-8'sd16, -8'sd4,  8'sd10, 8'sd50};
      5'd2:  b = '{-8'sd4,  8'sd4,   8'sd10, 8'sd50};
      5'd3:  b = '{8'sd4,   8'sd16,  8'sd10, 8'sd50};
      5'd4:  b = '{8'sd16,  8'sd50,  -8'sd1, 8'sd50};
      5'd5:  b = '{-8'sd16, -8'sd4,  -8'sd1, 8'sd10};
      5'd6:  b = '{-8'sd4,  8'sd4,   -8'sd1, 8'sd10};
      5'd7:  b = '{8'sd4,   8'sd16,  -8'sd1, 8'sd10};
      5'd8:  b = '{-8'sd16, -8'sd4,  -8'sd10, -8'sd1};
      5'd9:  b = '{-8'sd4,  8'sd4,   -8'sd10, -8'sd1};
      5'd10: b = '{8'sd4,   8'sd16,  -8'sd10, -8'sd1};
      5'd11: b = '{-8'sd16, -8'sd4,  -8'sd20, -8'sd10};
      5'd12: b = '{-8'sd4,  8'sd4,   -8'sd20, -8'sd10};
      5'd13: b = '{8'sd4,   8'sd16,  -8'sd20, -8'sd10};
      5'd14: b = '{-8'sd50, -8'sd16, -8'sd50, -8'sd1};
      5'd15: b = '{-8'sd16, 8'sd16,  -8'sd50, -8'sd20};
      5'd16: b = '{8'sd16,  8'sd50,  -8'sd50, -8'sd1};
      default: b = '{8'sd0, 8'sd0, 8'sd0, 8'sd0};
    endcase
    return b[c];
  endfunction

endpackage

// ----- sv/prwh_front.sv -----
module prwh_front
  import prwh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] ref_angle,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] radius,
  input  logic [15:0] angle,
  input  logic [15:0] pt_fraction,
  input  logic [15:0] pileup_weight,
  input  logic        last_candidate,
  output logic        job_valid,
  input  logic        job_ready,
  output job_t        job
);

  // stage 1: phase lookup and weight product
  logic               s1_v_r;
  logic [15:0]        s1_rad_r;
  logic [14:0]        s1_sm_r, s1_cm_r;
  logic               s1_sn_r, s1_cn_r;
  logic [31:0]        s1_prod_r;
  logic               s1_last_r;
  // stage 2: coordinates
  logic               s2_v_r;
  logic signed [COORD_W-1:0] s2_x_r, s2_y_r;
  logic [15:0]        s2_w_r;
  logic               s2_last_r;
  // stage 3: classified
  logic               s3_v_r;
  job_t               s3_job_r;

  logic        adv;
  logic [15:0] d;
  logic [16:0] dr;
  logic [7:0]  p, pc;
  logic [31:0] xm, ym;
  logic [17:0] xr, yr;
  logic [4:0]  bin_nxt;
  logic signed [COORD_W+7:0] x100, y100;

  assign adv      = !s3_v_r || job_ready;
  assign in_ready = adv;
  assign job_valid = s3_v_r;
  assign job      = s3_job_r;

  function automatic logic [14:0] sine_mag(input logic [7:0] ph);
    logic [6:0] r;
    r = {1'b0, ph[5:0]};
    return ph[6] ? quarter_sine(7'd64 - r) : quarter_sine(r);
  endfunction

  function automatic logic in_box(input logic signed [COORD_W+7:0] v,
                                  input logic signed [7:0] lo,
                                  input logic signed [7:0] hi);
    logic signed [COORD_W+7:0] l, h;
    l = (COORD_W+8)'(lo) * (COORD_W+8)'(16384);
    h = (COORD_W+8)'(hi) * (COORD_W+8)'(16384);
    return (v > l) && (v < h);
  endfunction

  always_comb begin
    d  = angle - ref_angle;
    dr = {1'b0, d} + 17'd128;
    p  = dr[15:8];
    pc = p + 8'd64;
    xm = s1_rad_r * {17'd0, s1_sm_r} + 32'd8192;
    ym = s1_rad_r * {17'd0, s1_cm_r} + 32'd8192;
    xr = xm[31:14];
    yr = ym[31:14];
    x100 = (COORD_W+8)'(s2_x_r) * (COORD_W+8)'(100);
    y100 = (COORD_W+8)'(s2_y_r) * (COORD_W+8)'(100);
    // the lowest-numbered matching region wins, else the catch-all bin
    bin_nxt = CATCH_BIN;
    for (int k = 16; k >= 0; k--) begin
      if (in_box(x100, box(5'(k), 2'd0), box(5'(k), 2'd1)) &&
          in_box(y100, box(5'(k), 2'd2), box(5'(k), 2'd3)))
        bin_nxt = 5'(k);
    end
  end

  // advance the pipeline whenever the output slot frees
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_rad_r  <= radius;
      s1_sm_r   <= sine_mag(p);
      s1_cm_r   <= sine_mag(pc);
      s1_sn_r   <= p[7];
      s1_cn_r   <= pc[7];
      s1_prod_r <= pt_fraction * pileup_weight;
      s1_last_r <= last_candidate;
      s2_x_r    <= s1_sn_r ? -COORD_W'(xr) : COORD_W'(xr);
      s2_y_r    <= s1_cn_r ? -COORD_W'(yr) : COORD_W'(yr);
      s2_w_r    <= 16'(({1'b0, s1_prod_r} + 33'd32768) >> 16);
      s2_last_r <= s1_last_r;
      s3_job_r.bin    <= bin_nxt;
      s3_job_r.weight <= s2_w_r;
      s3_job_r.last   <= s2_last_r;
    end
  end

endmodule

// ----- sv/prwh_queue.sv -----
module prwh_queue
  import prwh_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_job,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_job
);

  localparam int DEPTH = 4;
  job_t       mem_r [DEPTH];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = cnt_r != 3'(DEPTH);
  assign rd_valid = cnt_r != 3'd0;
  assign rd_job   = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  // hold words in arrival order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 2'd1;
      if (rd) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(wr) - 3'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_job;
  end

endmodule

// ----- sv/prwh_back.sv -----
module prwh_back
  import prwh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  output logic        out_tlast
);

  typedef enum logic [0:0] {ACCUM, DRAIN} state_t;

  state_t                 state_r;
  logic [SUM_WIDTH-1:0]   sums_r [NUM_BINS];
  logic [BIN_W-1:0]       idx_r;
  logic                   ov_r;
  logic [BIN_W-1:0]       ob_r;
  logic [31:0]            os_r;
  logic                   ol_r;
  logic [SUM_WIDTH:0]     add;
  logic                   take, slot_free;

  assign slot_free = !ov_r || out_tready;
  assign job_ready = state_r == ACCUM;
  assign take      = job_valid && job_ready;
  assign add       = {1'b0, sums_r[job.bin]} + (SUM_WIDTH+1)'(job.weight);

  assign out_tvalid = ov_r;
  assign out_tdata  = {3'd0, os_r, ob_r};
  assign out_tlast  = ol_r;

  // accumulate, then drain one bin a word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ACCUM;
      idx_r   <= '0;
      ov_r    <= 1'b0;
      for (int k = 0; k < NUM_BINS; k++) sums_r[k] <= '0;
    end else begin
      case (state_r)
        ACCUM: begin
          if (slot_free) ov_r <= 1'b0;
          if (take) begin
            sums_r[job.bin] <= add[SUM_WIDTH] ? '1 : add[SUM_WIDTH-1:0];
            if (job.last) begin
              state_r <= DRAIN;
              idx_r   <= '0;
            end
          end
        end
        DRAIN: begin
          if (slot_free) begin
            ov_r <= 1'b1;
            ob_r <= idx_r;
            os_r <= (SUM_WIDTH > 32 && |(sums_r[idx_r] >> 32)) ? 32'hFFFF_FFFF
                                                               : 32'(sums_r[idx_r]);
            ol_r <= idx_r == LAST_BIN_IDX;
            sums_r[idx_r] <= '0;
            idx_r <= idx_r + 5'd1;
            if (idx_r == LAST_BIN_IDX) state_r <= ACCUM;
          end
        end
        default: state_r <= ACCUM;
      endcase
    end
  end

endmodule

// ----- sv/polar_region_weighted_histogram.sv -----
// Polar-region weighted histogram.
// in_*  : one candidate per word; tdata = radius, angle, pt_fraction,
//         pileup_weight from bit 0 up; tlast marks the jet's last candidate.
// out_* : one word per bin; tdata = bin_index[4:0], bin_sum[36:5];
//         tlast marks bin 17.
// cfg_* : write enable and data for the reference angle.
// A three-stage front rotates, scales and classifies each candidate, one
// per cycle while the queue has room; a four-word queue feeds the back
// end, which adds one weight per cycle into the bin sums while it
// accumulates. A last candidate makes the back end emit 18 words, one per
// cycle while the receiver is ready; the front keeps taking candidates
// until the queue and front stages fill. Reset clears all bin sums and
// the reference angle. A stalled receiver holds the current result and
// stops the drain.
module polar_region_weighted_histogram
  import prwh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // radius, angle, pt_fraction, pileup_weight
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // bin_index, bin_sum, zero pad
  output logic        out_tlast
);

  logic [15:0] ref_r;
  logic        fj_v, fj_r, qj_v, qj_r;
  job_t        fj, qj;

  always_ff @(posedge clk) begin
    if (!rst_n) ref_r <= '0;
    else if (cfg_we) ref_r <= cfg_wdata;
  end

  prwh_front u_front (
    .clk, .rst_n, .ref_angle(ref_r),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .radius(in_tdata[15:0]), .angle(in_tdata[31:16]),
    .pt_fraction(in_tdata[47:32]), .pileup_weight(in_tdata[63:48]),
    .last_candidate(in_tlast),
    .job_valid(fj_v), .job_ready(fj_r), .job(fj)
  );

  prwh_queue u_queue (
    .clk, .rst_n, .wr_valid(fj_v), .wr_ready(fj_r), .wr_job(fj),
    .rd_valid(qj_v), .rd_ready(qj_r), .rd_job(qj)
  );

  prwh_back u_back (
    .clk, .rst_n, .job_valid(qj_v), .job_ready(qj_r), .job(qj),
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

endmodule

// ----- sv/prwh_checker.sv -----
module prwh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);

  // hold a stalled word
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");

  // last flag only on bin 17
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[4:0] == 5'd17)))
    else $error("last flag mismatch");

  // bins stay in range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[4:0] <= 5'd17)
    else $error("bin index out of range");

endmodule

bind polar_region_weighted_histogram prwh_checker u_chk (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata, .out_tlast
);
